FILE: rtl/ira_pkg.sv
// Package for the integer to radix ASCII converter: types, constants and
// small helper functions shared by the divider, the top level and the testbench.
// No dependencies.
package ira_pkg;

	// Default width of the signed input value.
	localparam int unsigned IRA_VALUE_BITS = 32;

	// Radix after reset and the bounds it is held to.
	localparam logic [4:0] IRA_RADIX_RESET = 5'd10;
	localparam logic [4:0] IRA_RADIX_MIN   = 5'd2;
	localparam logic [4:0] IRA_RADIX_MAX   = 5'd16;

	// ASCII code of the minus sign.
	localparam logic [6:0] IRA_CHAR_MINUS = 7'h2D;

	// Control state of the converter.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} ira_state_t;

	// Status that the serial divider reports to the top level.
	typedef struct packed {
		logic done;
		logic quot_nonzero;
	} ira_div_status_t;

	// Radix values outside 2..16 saturate to the nearest bound.
	function automatic logic [4:0] ira_sat_radix(input logic [4:0] r);
		logic [4:0] res;
		case (r) inside
			[5'd0:5'd1]:   res = IRA_RADIX_MIN;
			[5'd17:5'd31]: res = IRA_RADIX_MAX;
			default:       res = r;
		endcase
		return res;
	endfunction

	// Digit to ASCII, upper-case letters for ten to fifteen.
	function automatic logic [6:0] ira_digit_char(input logic [3:0] d);
		logic [6:0] c;
		case (d)
			4'd0:    c = 7'h30;
			4'd1:    c = 7'h31;
			4'd2:    c = 7'h32;
			4'd3:    c = 7'h33;
			4'd4:    c = 7'h34;
			4'd5:    c = 7'h35;
			4'd6:    c = 7'h36;
			4'd7:    c = 7'h37;
			4'd8:    c = 7'h38;
			4'd9:    c = 7'h39;
			4'd10:   c = 7'h41;
			4'd11:   c = 7'h42;
			4'd12:   c = 7'h43;
			4'd13:   c = 7'h44;
			4'd14:   c = 7'h45;
			default: c = 7'h46;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/ira_if.sv
// Valid/ready channel interfaces of the converter: one for the input value
// and one for the output characters. Depends on nothing.
interface ira_value_if #(
	parameter int unsigned VALUE_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface ira_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] character;
	logic       last;

	modport source(output valid, output character, output last, input ready);
	modport sink(input valid, input character, input last, output ready);
endinterface

FILE: rtl/integer_to_radix_ascii.sv
// Integer to radix ASCII converter, top level. Each digit comes from the
// one-bit-per-cycle serial divider; then characters leave at one per cycle
// while the receiver is ready.
// Reset clears control state and sets the radix to ten; digits need no reset.
// Depends on ira_pkg, ira_if and ira_serial_div.
module integer_to_radix_ascii #(
	parameter int unsigned VALUE_BITS = ira_pkg::IRA_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	ira_value_if.sink   number,
	ira_char_if.source  text
);
	import ira_pkg::*;

	localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

	ira_state_t state_q;
	ira_state_t state_d;

	logic [4:0]            radix_q;
	logic                  neg_q;
	logic [CNT_W-1:0]      count_q;
	logic [3:0]            stack_q [VALUE_BITS];
	logic                  out_valid_q;
	logic [6:0]            out_char_q;
	logic                  out_last_q;

	logic                  accept;
	logic                  load_ok;
	logic                  div_start;
	logic                  push;
	logic                  pop;
	logic                  load_out;
	logic [6:0]            load_char;
	logic                  load_last;
	logic                  more_digits;
	logic                  value_neg;
	logic [VALUE_BITS-1:0] value_bits;
	logic [VALUE_BITS-1:0] magnitude;
	logic [VALUE_BITS-1:0] dividend;

	ira_div_status_t       div_status;
	logic [3:0]            div_digit;
	logic [VALUE_BITS-1:0] div_quot;

	// Sign and magnitude of the incoming value.
	always_comb begin
		value_bits = number.value;
		value_neg  = value_bits[VALUE_BITS-1];
		magnitude  = value_neg ? (~value_bits + VALUE_BITS'(1)) : value_bits;
		dividend   = (state_q == ST_IDLE) ? magnitude : div_quot;
	end

	assign accept      = number.valid && number.ready;
	assign load_ok     = !out_valid_q || text.ready;
	assign more_digits = div_status.quot_nonzero && (count_q < CNT_W'(VALUE_BITS - 1));

	ira_serial_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.radix    (ira_sat_radix(radix_q)),
		.status   (div_status),
		.digit    (div_digit),
		.quotient (div_quot)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_status.done && !more_digits) begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (load_ok) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (load_ok && (count_q == CNT_W'(1))) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the state machine.
	always_comb begin
		number.ready = 1'b0;
		div_start    = 1'b0;
		push         = 1'b0;
		pop          = 1'b0;
		load_out     = 1'b0;
		load_char    = ira_digit_char(stack_q[0]);
		load_last    = (count_q == CNT_W'(1));
		case (state_q)
			ST_IDLE: begin
				number.ready = 1'b1;
				div_start    = accept;
			end
			ST_DIV: begin
				push      = div_status.done;
				div_start = div_status.done && more_digits;
			end
			ST_SIGN: begin
				load_out  = load_ok;
				load_char = IRA_CHAR_MINUS;
				load_last = 1'b0;
			end
			ST_EMIT: begin
				load_out = load_ok;
				pop      = load_ok;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= IRA_RADIX_RESET;
			neg_q       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) radix_q <= cfg_wdata;
			if (accept) begin
				neg_q   <= value_neg;
				count_q <= '0;
			end else if (push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Digit stack: digits arrive least significant first and leave from the top.
	always_ff @(posedge clk) begin
		if (push) begin
			stack_q[0] <= div_digit;
			for (int i = 1; i < VALUE_BITS; i++) stack_q[i] <= stack_q[i-1];
		end else if (pop) begin
			for (int i = 0; i < VALUE_BITS - 1; i++) stack_q[i] <= stack_q[i+1];
		end
	end

	// Output register holding one character request.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_char_q <= load_char;
			out_last_q <= load_last;
		end
	end

	assign text.valid     = out_valid_q;
	assign text.character = out_char_q;
	assign text.last      = out_last_q;

endmodule

FILE: rtl/ira_serial_div.sv
// Bit-serial restoring divider: divides an unsigned value by a radix of at most
// sixteen, one quotient bit per cycle. Depends on ira_pkg.
module ira_serial_div #(
	parameter int unsigned VALUE_BITS = ira_pkg::IRA_VALUE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [VALUE_BITS-1:0]          dividend,
	input  logic [4:0]                     radix,
	output ira_pkg::ira_div_status_t       status,
	output logic [3:0]                     digit,
	output logic [VALUE_BITS-1:0]          quotient
);
	import ira_pkg::*;

	localparam int unsigned CW = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] quot_q;
	logic [3:0]            rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  running_q;
	logic                  done_q;
	logic                  nz_q;

	logic [4:0] trial;
	logic [4:0] diff;
	logic       ge;

	// One long-division step: bring down the next dividend bit.
	always_comb begin
		trial = {rem_q, quot_q[VALUE_BITS-1]};
		ge    = (trial >= radix);
		diff  = trial - radix;
	end

	// Control: step counter, busy flag and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			running_q <= 1'b0;
			done_q    <= 1'b0;
			nz_q      <= 1'b0;
		end else if (start) begin
			cnt_q     <= CW'(VALUE_BITS - 1);
			running_q <= 1'b1;
			done_q    <= 1'b0;
			nz_q      <= 1'b0;
		end else begin
			done_q <= running_q && (cnt_q == '0);
			if (running_q) begin
				nz_q <= nz_q | ge;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: quotient bits shift in as dividend bits shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (running_q) begin
			quot_q <= {quot_q[VALUE_BITS-2:0], ge};
			rem_q  <= ge ? diff[3:0] : trial[3:0];
		end
	end

	assign status.done         = done_q;
	assign status.quot_nonzero = nz_q;
	assign digit               = rem_q;
	assign quotient            = quot_q;

endmodule

FILE: verif/tb_integer_to_radix_ascii.sv
// Self-checking testbench for the integer to radix ASCII converter.
// A directed table runs first, then random values under several radix settings.
// Depends on ira_pkg, ira_if and the integer_to_radix_ascii RTL.
module tb_integer_to_radix_ascii;
	import ira_pkg::*;

	localparam int unsigned VALUE_BITS  = IRA_VALUE_BITS;
	localparam int unsigned N_DIRECTED  = 25;
	localparam int unsigned N_PHASES    = 7;
	localparam int unsigned PHASE_ITEMS = 36;
	localparam int unsigned MAX_GAP     = 16;
	localparam int unsigned LONG_HOLD   = 3000;
	localparam int unsigned SETTLE      = 40;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	localparam logic [6:0] CHAR_ZERO     = 7'h30;
	localparam logic [6:0] CHAR_LETTER_A = 7'h41;

	// One output character as the block should deliver it.
	typedef struct packed {
		logic [6:0] character;
		logic       last;
	} char_result_t;

	// One directed request; an empty text means the predictor supplies it.
	typedef struct {
		logic [4:0]                   radix_set;
		logic signed [VALUE_BITS-1:0] value;
		string                        text;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_wdata;

	ira_value_if #(.VALUE_BITS(VALUE_BITS)) number_ch ();
	ira_char_if text_ch ();

	integer_to_radix_ascii #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.number(number_ch),
		.text(text_ch)
	);

	char_result_t expected_chars[$];
	string typed_text_q[$];
	logic [4:0] radix_setting = IRA_RADIX_RESET;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;
	bit long_hold_req = 1'b0;

	string accepted_text;
	char_result_t want;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{5'd10, 32'sd0, "0"},
		'{5'd10, 32'sd1, "1"},
		'{5'd10, -32'sd1, "-1"},
		'{5'd10, 32'sd9, "9"},
		'{5'd10, 32'sd10, "10"},
		'{5'd10, 32'h7FFF_FFFF, "2147483647"},
		'{5'd10, 32'h8000_0000, "-2147483648"},
		'{5'd10, -32'sd12345, ""},
		'{5'd16, 32'sd255, "FF"},
		'{5'd16, 32'h7FFF_FFFF, "7FFFFFFF"},
		'{5'd16, 32'h8000_0000, "-80000000"},
		'{5'd16, 32'hFEDC_BA98, ""},
		'{5'd16, 32'h00AB_CDEF, "ABCDEF"},
		'{5'd2, 32'sd0, "0"},
		'{5'd2, -32'sd1, "-1"},
		'{5'd2, 32'h7FFF_FFFF, {"1111111111", "1111111111", "1111111111", "1"}},
		'{5'd2, 32'h8000_0000, {"-1", "0000000000", "0000000000", "0000000000", "0"}},
		'{5'd0, 32'sd5, "101"},
		'{5'd1, -32'sd6, "-110"},
		'{5'd31, 32'sd255, "FF"},
		'{5'd17, -32'sd255, "-FF"},
		'{5'd3, 32'sd1000, ""},
		'{5'd7, -32'sd98765, ""},
		'{5'd12, 32'sd12345678, ""},
		'{5'd8, 32'h8000_0000, "-20000000000"}
	};

	// Free-running clock, period 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the characters the block should emit for one value under the
	// current radix and appends them to the expected queue.
	function automatic void predict_text(input logic signed [VALUE_BITS-1:0] v);
		logic [VALUE_BITS-1:0] magnitude;
		logic [VALUE_BITS-1:0] base;
		logic [3:0] digits [VALUE_BITS];
		int count;
		bit negative;
		char_result_t res;
		negative = v[VALUE_BITS-1];
		magnitude = negative ? (~v + 1'b1) : v;
		if (radix_setting < IRA_RADIX_MIN) begin
			base = VALUE_BITS'(IRA_RADIX_MIN);
		end else if (radix_setting > IRA_RADIX_MAX) begin
			base = VALUE_BITS'(IRA_RADIX_MAX);
		end else begin
			base = VALUE_BITS'(radix_setting);
		end
		count = 0;
		do begin
			digits[count] = 4'(magnitude % base);
			count++;
			magnitude = magnitude / base;
		end while (magnitude != 0 && count < VALUE_BITS);
		if (negative) begin
			res.character = IRA_CHAR_MINUS;
			res.last = 1'b0;
			expected_chars.push_back(res);
		end
		for (int k = count - 1; k >= 0; k--) begin
			if (digits[k] < 4'd10) begin
				res.character = CHAR_ZERO + digits[k];
			end else begin
				res.character = CHAR_LETTER_A + digits[k] - 7'd10;
			end
			res.last = (k == 0);
			expected_chars.push_back(res);
		end
	endfunction

	// Random values: extremes, full-width words, small magnitudes, random lengths.
	function automatic logic signed [VALUE_BITS-1:0] random_value();
		logic signed [VALUE_BITS-1:0] v;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 4))
				0: v = '0;
				1: v = '1;
				2: v = 1;
				3: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
				default: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
			endcase
		end else if (pick <= 3) begin
			v = $urandom;
		end else if (pick <= 6) begin
			v = $urandom_range(0, 255);
			if ($urandom_range(0, 1) == 1) v = -v;
		end else begin
			v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
			if ($urandom_range(0, 1) == 1) v = -v;
		end
		return v;
	endfunction

	// Offers one request after a random gap (none in burst mode) and holds it until it is taken.
	task automatic send_value(input logic signed [VALUE_BITS-1:0] v, input string text);
		int unsigned gap;
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			number_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_text_q.push_back(text);
		number_ch.valid <= 1'b1;
		number_ch.value <= v;
		@(posedge clk);
		while (!number_ch.ready) @(posedge clk);
	endtask

	// Drops valid and waits until every expected character has arrived.
	task automatic wait_idle();
		number_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes the radix register; the block is idle whenever this is called.
	task automatic write_radix(input logic [4:0] r);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix_setting = r;
	endtask

	// Receiver: random stalls per character (none in burst mode), and one long hold when requested.
	initial begin
		int unsigned gap;
		text_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				text_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end
			gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (gap != 0) begin
				text_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			text_ch.ready <= 1'b1;
			@(posedge clk);
			while (!text_ch.valid) @(posedge clk);
		end
	end

	// Predicts on each accepted request and checks each accepted character.
	always @(posedge clk) begin
		if (arst_n) begin
			if (number_ch.valid && number_ch.ready) begin
				accepted_text = typed_text_q.pop_front();
				if (accepted_text.len() != 0) begin
					for (int k = 0; k < accepted_text.len(); k++) begin
						want.character = 7'(accepted_text[k]);
						want.last = (k == accepted_text.len() - 1);
						expected_chars.push_back(want);
					end
				end else begin
					predict_text(number_ch.value);
				end
			end
			if (text_ch.valid && text_ch.ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected character, expected none, actual %h last %b",
						$time, text_ch.character, text_ch.last);
					errors++;
				end else begin
					want = expected_chars.pop_front();
					if (text_ch.character !== want.character) begin
						$display("%0t: character mismatch, expected %h, actual %h",
							$time, want.character, text_ch.character);
						errors++;
					end
					if (text_ch.last !== want.last) begin
						$display("%0t: last flag mismatch, expected %b, actual %b",
							$time, want.last, text_ch.last);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random phases, verdict.
	initial begin
		logic [4:0] phase_radix [N_PHASES];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		number_ch.valid = 1'b0;
		number_ch.value = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; the radix changes only with the block drained.
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (directed_rows[i].radix_set != radix_setting) begin
				wait_idle();
				write_radix(directed_rows[i].radix_set);
			end
			send_value(directed_rows[i].value, directed_rows[i].text);
		end

		// Random phases, each under its own radix setting.
		phase_radix[0] = 5'd10;
		phase_radix[1] = 5'd16;
		phase_radix[2] = 5'($urandom_range(0, 31));
		phase_radix[3] = 5'd2;
		phase_radix[4] = 5'($urandom_range(3, 15));
		phase_radix[5] = 5'($urandom_range(0, 31));
		phase_radix[6] = 5'($urandom_range(2, 16));
		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			write_radix(phase_radix[p]);
			// Phase 1 holds the receiver off while requests keep coming;
			// phase 4 runs with no idling on either side.
			send_burst = (p == 1) || (p == 4);
			recv_burst = (p == 4);
			if (p == 1) long_hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_value(random_value(), "");
			end
		end

		wait_idle();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
